### rtl/crc8fr_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and the CRC-8 fold for the framed receiver.
// No dependencies; every other file imports this package.
package crc8fr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LIMIT_W = 4;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned BEAT_W  = 2;

   localparam logic [BYTE_W-1:0]  CHAR_END   = 8'd59;  // ';'
   localparam logic [BYTE_W-1:0]  CHAR_BANG  = 8'd33;  // '!'
   localparam logic [BYTE_W-1:0]  CHAR_SPACE = 8'd32;  // ' '
   localparam logic [BYTE_W-1:0]  CRC_POLY   = 8'h8C;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

   localparam logic [BEAT_W-1:0] BEAT_FIRST  = 2'd0;
   localparam logic [BEAT_W-1:0] BEAT_SECOND = 2'd1;
   localparam logic [BEAT_W-1:0] BEAT_FINAL  = 2'd2;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_DONE   = 2'd2;

   typedef enum logic [2:0] {
      EV_GOOD         = 3'd0,
      EV_RESEND       = 3'd1,
      EV_NACK_GIVE_UP = 3'd2,
      EV_CRC_NACK     = 3'd3,
      EV_CRC_GIVE_UP  = 3'd4,
      EV_ACK          = 3'd5
   } frame_event_type;

   // Outcome of one frame, handed from the judge to the reply serializer.
   typedef struct packed {
      frame_event_type        frame_event;
      logic [COUNT_W-1:0]     retry_count;
   } reply_desc_type;

   // Reflected CRC-8, one data byte folded in LSB first.
   function automatic logic [BYTE_W-1:0] crc_fold(input logic [BYTE_W-1:0] crc_val,
                                                  input logic [BYTE_W-1:0] data_val);
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] d;
      c = crc_val;
      d = data_val;
      for (int b = 0; b < BYTE_W; b++) begin
         if ((c[0] ^ d[0]) == 1'b1) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         d = d >> 1;
      end
      return c;
   endfunction

   // Events whose reply is three transmitted bytes.
   function automatic logic is_multi_beat(input frame_event_type ev);
      return (ev == EV_GOOD) || (ev == EV_CRC_NACK);
   endfunction

endpackage

### rtl/crc8fr_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and reply beats.
// Depends on crc8fr_pkg for the field widths.
interface crc8fr_req_if;
   import crc8fr_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crc8fr_rsp_if;
   import crc8fr_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  tx_byte;
   logic               tx_valid;
   logic [2:0]         frame_event;
   logic [COUNT_W-1:0] retry_count_now;
   logic               last;

   modport source (output valid, output tx_byte, output tx_valid, output frame_event,
                   output retry_count_now, output last, input ready);
   modport sink   (input valid, input tx_byte, input tx_valid, input frame_event,
                   input retry_count_now, input last, output ready);
endinterface

### rtl/crc8fr_judge.sv
`timescale 1ns / 1ps
// Input register, CRC and frame state, retry limit register and frame verdict.
// Depends on crc8fr_pkg and crc8fr_req_if.
module crc8fr_judge
   import crc8fr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   crc8fr_req_if.sink         req_chan,
   output logic               desc_valid,
   output reply_desc_type     desc,
   input  logic               desc_ready
);

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [BYTE_W-1:0]  crc_ff;
   logic [BYTE_W-1:0]  first_ff;
   logic [BYTE_W-1:0]  second_ff;
   logic [1:0]         pos_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [COUNT_W-1:0] count_in;
   logic               is_end;
   logic               advance;
   logic               retries_remain;
   logic               is_nack;
   logic               is_ack;

   assign is_end  = (in_byte_ff == CHAR_END);
   // A terminator waits until the serializer can hold its reply; data beats never wait.
   assign advance = in_valid_ff && (!is_end || desc_ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign retries_remain = (count_ff <= {1'b0, limit_ff});
   assign is_nack = (first_ff == CHAR_BANG) && (second_ff == CHAR_BANG);
   assign is_ack  = (first_ff == CHAR_BANG) && (second_ff == CHAR_SPACE);

   always_comb begin
      desc.frame_event = EV_GOOD;
      count_in         = '0;
      priority if (is_nack) begin
         if (retries_remain) begin
            desc.frame_event = EV_RESEND;
            count_in         = COUNT_W'(count_ff + 1'b1);
         end else begin
            desc.frame_event = EV_NACK_GIVE_UP;
         end
      end else if (is_ack) begin
         desc.frame_event = EV_ACK;
         count_in         = count_ff;
      end else if (crc_ff != '0) begin
         if (retries_remain) begin
            desc.frame_event = EV_CRC_NACK;
            count_in         = COUNT_W'(count_ff + 1'b1);
         end else begin
            desc.frame_event = EV_CRC_GIVE_UP;
         end
      end else begin
         desc.frame_event = EV_GOOD;
      end
      desc.retry_count = count_in;
   end

   assign desc_valid = in_valid_ff && is_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         first_ff  <= '0;
         second_ff <= '0;
         pos_ff    <= POS_FIRST;
         count_ff  <= '0;
      end else if (advance) begin
         if (is_end) begin
            crc_ff    <= '0;
            first_ff  <= '0;
            second_ff <= '0;
            pos_ff    <= POS_FIRST;
            count_ff  <= count_in;
         end else begin
            crc_ff <= crc_fold(crc_ff, in_byte_ff);
            if (pos_ff == POS_FIRST) begin
               first_ff <= in_byte_ff;
            end
            if (pos_ff == POS_SECOND) begin
               second_ff <= in_byte_ff;
            end
            if (pos_ff != POS_DONE) begin
               pos_ff <= 2'(pos_ff + 1'b1);
            end
         end
      end
   end

endmodule

### rtl/crc8fr_reply.sv
`timescale 1ns / 1ps
// Holds one frame verdict and plays it out as one or three reply beats.
// Depends on crc8fr_pkg and crc8fr_rsp_if.
module crc8fr_reply
   import crc8fr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   input  reply_desc_type desc,
   output logic           desc_ready,
   crc8fr_rsp_if.source   rsp_chan
);

   logic                held_ff;
   reply_desc_type      desc_ff;
   logic [BEAT_W-1:0]   beat_ff;

   logic multi;
   logic final_beat;
   logic beat_taken;
   logic pop;

   assign multi      = is_multi_beat(desc_ff.frame_event);
   assign final_beat = !multi || (beat_ff == BEAT_FINAL);
   assign beat_taken = held_ff && rsp_chan.ready;
   assign pop        = beat_taken && final_beat;
   assign desc_ready = !held_ff || pop;

   always_comb begin
      rsp_chan.tx_byte = '0;
      if (multi) begin
         unique case (beat_ff)
            BEAT_FIRST:  rsp_chan.tx_byte = CHAR_BANG;
            BEAT_SECOND: rsp_chan.tx_byte =
               (desc_ff.frame_event == EV_GOOD) ? CHAR_SPACE : CHAR_BANG;
            BEAT_FINAL:  rsp_chan.tx_byte = CHAR_END;
            default:     rsp_chan.tx_byte = '0;
         endcase
      end
   end

   assign rsp_chan.valid           = held_ff;
   assign rsp_chan.tx_valid        = multi;
   assign rsp_chan.frame_event     = 3'(desc_ff.frame_event);
   assign rsp_chan.retry_count_now = desc_ff.retry_count;
   assign rsp_chan.last            = final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         beat_ff <= BEAT_FIRST;
      end else if (desc_valid && desc_ready) begin
         held_ff <= 1'b1;
         beat_ff <= BEAT_FIRST;
      end else if (pop) begin
         held_ff <= 1'b0;
      end else if (beat_taken) begin
         beat_ff <= BEAT_W'(beat_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (desc_valid && desc_ready) begin
         desc_ff <= desc;
      end
   end

endmodule

### rtl/crc8_frame_receiver_with_retry_top.sv
`timescale 1ns / 1ps
// Channel     Dir  Handshake          Beat contents
// req_chan    in   valid/ready        rx_byte
// rsp_chan    out  valid/ready        tx_byte, tx_valid, frame_event, retry_count_now, last
// csr_*       in   write enable only  retry_limit
//
// A received byte is taken into an input register and folded into the frame
// state in the next cycle, so a byte can be accepted every cycle unless a ';' waits.
// A ';' produces one reply beat, or three for an ACK or NACK sent back; the
// serializer holds one frame's reply while the next frame's bytes keep coming.
// A second ';' waits in the input register until the previous reply is drained.
// Reset is synchronous and restores retry_limit to 3 and clears all frame state.
module crc8_frame_receiver_with_retry_top
   import crc8fr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [LIMIT_W-1:0] csr_write_data,
   crc8fr_req_if.sink         req_chan,
   crc8fr_rsp_if.source       rsp_chan
);

   logic           desc_valid;
   logic           desc_ready;
   reply_desc_type desc;

   crc8fr_judge u_judge (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .desc_valid       (desc_valid),
      .desc             (desc),
      .desc_ready       (desc_ready)
   );

   crc8fr_reply u_reply (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (desc_valid),
      .desc       (desc),
      .desc_ready (desc_ready),
      .rsp_chan   (rsp_chan)
   );

   // A handed-over verdict shows up on the reply channel next cycle.
   assert property (@(posedge clock) disable iff (reset)
      desc_valid && desc_ready |=> rsp_chan.valid)
      else $error("verdict handed over but no reply beat followed");

   // Only transmitted replies span more than one beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last |-> rsp_chan.tx_valid)
      else $error("non-final beat without a byte to transmit");

   // Beats of one reply share the verdict and count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last |=>
         rsp_chan.valid && $stable(rsp_chan.frame_event)
         && $stable(rsp_chan.retry_count_now))
      else $error("reply beats of one frame disagree");

   // The count never goes past one above the largest possible limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.retry_count_now <= 5'd16)
      else $error("retry count out of range");

endmodule
